FILE: hdl/dts_pkg.sv
// shared types, codes and keyword tables for the datalog token scanner
`default_nettype none

package dts_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int FIELD_W         = 16;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [3:0] kind_t;

  localparam kind_t KIND_COMMA     = 4'd0;
  localparam kind_t KIND_PERIOD    = 4'd1;
  localparam kind_t KIND_QMARK     = 4'd2;
  localparam kind_t KIND_LPAREN    = 4'd3;
  localparam kind_t KIND_RPAREN    = 4'd4;
  localparam kind_t KIND_COLON     = 4'd5;
  localparam kind_t KIND_COLONDASH = 4'd6;
  localparam kind_t KIND_SCHEMES   = 4'd7;
  localparam kind_t KIND_FACTS     = 4'd8;
  localparam kind_t KIND_RULES     = 4'd9;
  localparam kind_t KIND_QUERIES   = 4'd10;
  localparam kind_t KIND_ID        = 4'd11;
  localparam kind_t KIND_STRING    = 4'd12;
  localparam kind_t KIND_ERROR     = 4'd13;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_STRING,
    MODE_COLON,
    MODE_COMMENT,
    MODE_HALT
  } mode_t;

  typedef enum logic [2:0] {
    KW_NONE,
    KW_SCHEMES,
    KW_FACTS,
    KW_RULES,
    KW_QUERIES
  } kw_t;

  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_PERIOD = 8'd46;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_QUOTE  = 8'd39;

  // one result word
  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] len;
    logic               last;
  } token_t;

  // characters that must follow the first letter of each keyword
  function automatic logic [2:0] kw_tail_len(input kw_t kw);
    logic [2:0] n;
    case (kw)
      KW_SCHEMES: n = 3'd6;
      KW_FACTS:   n = 3'd4;
      KW_RULES:   n = 3'd4;
      KW_QUERIES: n = 3'd6;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_tail_char(input kw_t kw, input logic [2:0] p);
    logic [7:0] c;
    c = CH_NUL;
    case (kw)
      KW_SCHEMES: begin
        case (p)
          3'd0:    c = "c";
          3'd1:    c = "h";
          3'd2:    c = "e";
          3'd3:    c = "m";
          3'd4:    c = "e";
          3'd5:    c = "s";
          default: c = CH_NUL;
        endcase
      end
      KW_FACTS: begin
        case (p)
          3'd0:    c = "a";
          3'd1:    c = "c";
          3'd2:    c = "t";
          3'd3:    c = "s";
          default: c = CH_NUL;
        endcase
      end
      KW_RULES: begin
        case (p)
          3'd0:    c = "u";
          3'd1:    c = "l";
          3'd2:    c = "e";
          3'd3:    c = "s";
          default: c = CH_NUL;
        endcase
      end
      KW_QUERIES: begin
        case (p)
          3'd0:    c = "u";
          3'd1:    c = "e";
          3'd2:    c = "r";
          3'd3:    c = "i";
          3'd4:    c = "e";
          3'd5:    c = "s";
          default: c = CH_NUL;
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/dts_core.sv
// scanner state and per-byte token logic, up to two result words per step
`default_nettype none

module dts_core
  import dts_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  output logic [1:0]      res_cnt,
  output token_t          res0,
  output token_t          res1
);

  localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

  mode_t                  mode, mode_next;
  logic [COUNT_WIDTH-1:0] line_count, line_count_next;
  logic [COUNT_WIDTH-1:0] column_count, column_count_next;
  logic [COUNT_WIDTH-1:0] token_start, token_start_next;
  logic [COUNT_WIDTH-1:0] token_len, token_len_next;
  kw_t                    kw_cand, kw_cand_next;
  logic                   kw_match, kw_match_next;

  logic                   pre_v, st_v, rescan, is_nl;
  token_t                 pre_tok, st_tok;
  kind_t                  id_kind;
  logic [COUNT_WIDTH-1:0] kw_pos;
  logic                   kw_miss;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + ONE;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic token_t mk_tok(input kind_t k, input logic [COUNT_WIDTH-1:0] ln,
                                    input logic [COUNT_WIDTH-1:0] c,
                                    input logic [COUNT_WIDTH-1:0] n);
    token_t t;
    t.kind = k;
    t.line = FIELD_W'(ln);
    t.col  = FIELD_W'(c);
    t.len  = FIELD_W'(n);
    t.last = 1'b0;
    return t;
  endfunction

  // whole-word keyword check for the identifier being closed
  always_comb begin
    id_kind = KIND_ID;
    if (kw_cand != KW_NONE && kw_match &&
        token_len == COUNT_WIDTH'(kw_tail_len(kw_cand)) + ONE) begin
      case (kw_cand)
        KW_SCHEMES: id_kind = KIND_SCHEMES;
        KW_FACTS:   id_kind = KIND_FACTS;
        KW_RULES:   id_kind = KIND_RULES;
        KW_QUERIES: id_kind = KIND_QUERIES;
        default:    id_kind = KIND_ID;
      endcase
    end
  end

  assign kw_pos  = token_len - ONE;
  assign kw_miss = (kw_pos >= COUNT_WIDTH'(kw_tail_len(kw_cand))) ||
                   (kw_tail_char(kw_cand, kw_pos[2:0]) != in_byte);
  assign is_nl   = (in_byte == CH_NL);

  always_comb begin
    mode_next         = mode;
    line_count_next   = line_count;
    column_count_next = column_count;
    token_start_next  = token_start;
    token_len_next    = token_len;
    kw_cand_next      = kw_cand;
    kw_match_next     = kw_match;
    pre_v             = 1'b0;
    st_v              = 1'b0;
    rescan            = 1'b0;
    pre_tok           = mk_tok(KIND_ID, line_count, token_start, token_len);
    st_tok            = mk_tok(KIND_ERROR, line_count, column_count, '0);

    if (mode == MODE_HALT) begin
      mode_next = MODE_HALT;
    end else if (end_of_input) begin
      case (mode)
        MODE_IDENT: begin
          pre_v   = 1'b1;
          pre_tok = mk_tok(id_kind, line_count, token_start, token_len);
        end
        MODE_COLON: begin
          pre_v   = 1'b1;
          pre_tok = mk_tok(KIND_COLON, line_count, token_start, ONE);
        end
        MODE_STRING: begin
          pre_v   = 1'b1;
          pre_tok = mk_tok(KIND_ERROR, line_count, token_start, '0);
        end
        default: pre_v = 1'b0;
      endcase
      if (mode == MODE_STRING) begin
        mode_next = MODE_HALT;
      end else begin
        // ready for a fresh document
        mode_next         = MODE_IDLE;
        line_count_next   = ONE;
        column_count_next = '0;
        token_start_next  = '0;
        token_len_next    = '0;
        kw_cand_next      = KW_NONE;
        kw_match_next     = 1'b0;
      end
    end else begin
      case (mode)
        MODE_COMMENT: begin
          if (is_nl) mode_next = MODE_IDLE;
        end
        MODE_STRING: begin
          if (in_byte == CH_QUOTE) begin
            pre_v     = 1'b1;
            pre_tok   = mk_tok(KIND_STRING, line_count, token_start, token_len);
            mode_next = MODE_IDLE;
          end else if (is_nl || in_byte == CH_NUL) begin
            pre_v     = 1'b1;
            pre_tok   = mk_tok(KIND_ERROR, line_count, token_start, '0);
            mode_next = MODE_HALT;
          end else begin
            token_len_next = sat_inc(token_len);
          end
        end
        MODE_IDENT: begin
          if (is_alnum(in_byte)) begin
            if (kw_match && kw_cand != KW_NONE && kw_miss) kw_match_next = 1'b0;
            token_len_next = sat_inc(token_len);
          end else begin
            pre_v     = 1'b1;
            pre_tok   = mk_tok(id_kind, line_count, token_start, token_len);
            mode_next = MODE_IDLE;
            rescan    = 1'b1;
          end
        end
        MODE_COLON: begin
          pre_v     = 1'b1;
          mode_next = MODE_IDLE;
          if (in_byte == CH_DASH) begin
            pre_tok = mk_tok(KIND_COLONDASH, line_count, token_start, COUNT_WIDTH'(2));
          end else begin
            pre_tok = mk_tok(KIND_COLON, line_count, token_start, ONE);
            rescan  = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase

      // byte starts something new
      if (rescan && !is_nl) begin
        case (in_byte)
          CH_COMMA: begin
            st_v = 1'b1; st_tok = mk_tok(KIND_COMMA, line_count, column_count, ONE);
          end
          CH_PERIOD: begin
            st_v = 1'b1; st_tok = mk_tok(KIND_PERIOD, line_count, column_count, ONE);
          end
          CH_QMARK: begin
            st_v = 1'b1; st_tok = mk_tok(KIND_QMARK, line_count, column_count, ONE);
          end
          CH_LPAREN: begin
            st_v = 1'b1; st_tok = mk_tok(KIND_LPAREN, line_count, column_count, ONE);
          end
          CH_RPAREN: begin
            st_v = 1'b1; st_tok = mk_tok(KIND_RPAREN, line_count, column_count, ONE);
          end
          CH_HASH: mode_next = MODE_COMMENT;
          CH_COLON: begin
            mode_next        = MODE_COLON;
            token_start_next = column_count;
          end
          CH_QUOTE: begin
            mode_next        = MODE_STRING;
            token_start_next = column_count;
            token_len_next   = '0;
          end
          default: begin
            if (in_byte == CH_NUL || in_byte == CH_SPACE ||
                (in_byte >= CH_TAB && in_byte <= CH_CR)) begin
              mode_next = mode_next;
            end else if (is_alpha(in_byte)) begin
              mode_next        = MODE_IDENT;
              token_start_next = column_count;
              token_len_next   = ONE;
              case (in_byte)
                "S":     kw_cand_next = KW_SCHEMES;
                "F":     kw_cand_next = KW_FACTS;
                "R":     kw_cand_next = KW_RULES;
                "Q":     kw_cand_next = KW_QUERIES;
                default: kw_cand_next = KW_NONE;
              endcase
              kw_match_next = (kw_cand_next != KW_NONE);
            end else begin
              st_v      = 1'b1;
              mode_next = MODE_HALT;
            end
          end
        endcase
      end

      if (is_nl && mode_next != MODE_HALT) begin
        line_count_next   = sat_inc(line_count);
        column_count_next = '0;
      end else begin
        column_count_next = sat_inc(column_count);
      end
    end
  end

  always_comb begin
    res_cnt = {1'b0, pre_v} + {1'b0, st_v};
    res0    = pre_v ? pre_tok : st_tok;
    res1    = st_tok;
    res0.last = (res_cnt == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      line_count   <= ONE;
      column_count <= '0;
      token_start  <= '0;
      token_len    <= '0;
      kw_cand      <= KW_NONE;
      kw_match     <= 1'b0;
    end else if (step) begin
      mode         <= mode_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
      token_start  <= token_start_next;
      token_len    <= token_len_next;
      kw_cand      <= kw_cand_next;
      kw_match     <= kw_match_next;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_HALT |-> res_cnt == 2'd0 && mode_next == MODE_HALT)
    else $error("scanner produced output after halt");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0)
    else $error("line counter reached zero");

  a_match_has_cand: assert property (@(posedge clk) disable iff (rst)
    kw_match |-> kw_cand != KW_NONE)
    else $error("keyword match flag set without a candidate");

endmodule

`default_nettype wire

FILE: hdl/dts_out_fifo.sv
// small result queue: takes up to two words a cycle, gives one while it holds a word and out_ready is high
`default_nettype none

module dts_out_fifo
  import dts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] push_cnt,
  input  wire token_t     push0,
  input  wire token_t     push1,
  output logic            room2,
  output logic            out_valid,
  input  wire logic       out_ready,
  output token_t          out_word
);

  token_t                entry [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  pop;
  logic [FIFO_PTR_W-1:0] wr_ptr1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_word  = entry[rd_ptr];
  assign wr_ptr1   = wr_ptr + FIFO_PTR_W'(1);
  // two free slots once this cycle's pop is counted
  assign room2     = (count - FIFO_CNT_W'(pop)) <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) entry[wr_ptr] <= push0;
    if (push_cnt == 2'd2) entry[wr_ptr1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_cnt);
      if (pop) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      count  <= count + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_cnt != 2'd0 |-> room2)
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

endmodule

`default_nettype wire

FILE: hdl/datalog_token_scanner.sv
// top level of the datalog token scanner: input register, scanner, result queue
// an accepted input word is held in the input register; its results are registered in the queue
// throughput: one input word per cycle while the queue has room for two words; an input
// giving two results needs more output drain, since the queue sends at most one word per cycle
// reset: synchronous, clears scanner state to line 1 column 0 and empties the queue
`default_nettype none

module datalog_token_scanner
  import dts_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tuser,   // [0] end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [15:0] line_number, [31:16] start_column,
                                           // [47:32] token_length
  output logic [3:0]       m_axis_tuser,   // [3:0] token_kind
  output logic             m_axis_tlast    // last_of_run
);

  logic       in_v;
  logic [7:0] in_byte;
  logic       in_eoi;
  logic       step;
  logic       room2;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  token_t     res0, res1, out_word;

  assign step          = in_v && room2;
  assign s_axis_tready = !in_v || step;
  assign push_cnt      = step ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v <= 1'b1;
    end else if (step) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eoi  <= s_axis_tuser;
    end
  end

  dts_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .in_byte      (in_byte),
    .end_of_input (in_eoi),
    .res_cnt      (res_cnt),
    .res0         (res0),
    .res1         (res1)
  );

  dts_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  assign m_axis_tdata = {out_word.len, out_word.col, out_word.line};
  assign m_axis_tuser = out_word.kind;
  assign m_axis_tlast = out_word.last;

  a_word_held: assert property (@(posedge clk) disable iff (rst)
    in_v && !step |=> in_v && $stable(in_byte) && $stable(in_eoi))
    else $error("pending input word lost while stalled");

endmodule

`default_nettype wire

FILE: sim/datalog_token_scanner_tb.sv
// self-checking testbench for the datalog token scanner: byte stimulus, token predictor, scoreboard
module datalog_token_scanner_tb;
  import dts_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
  logic        s_axis_tuser = 1'b0; // [0] end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [15:0] line_number, [31:16] start_column,
                                    // [47:32] token_length
  logic [3:0]  m_axis_tuser;        // [3:0] token_kind
  logic        m_axis_tlast;

  datalog_token_scanner u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // lexer state mirrored by the predictor
  mode_t       lex_mode;
  logic [15:0] lex_line;
  logic [15:0] lex_col;
  logic [15:0] lex_start;
  logic [15:0] lex_len;
  kw_t         lex_kw;
  logic        lex_kw_ok;

  token_t expected_tokens[$];
  token_t want_tok;
  int     step_results;
  int     error_count = 0;
  int     words_sent = 0;
  bit     send_idle_on = 1'b1;
  bit     recv_idle_on = 1'b1;
  int     ready_hold = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [15:0] sat_bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_NUL || b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit starts_token(input logic [7:0] b);
    return is_letter(b) || is_blank(b) || b == CH_COMMA || b == CH_PERIOD ||
           b == CH_QMARK || b == CH_LPAREN || b == CH_RPAREN || b == CH_HASH ||
           b == CH_COLON || b == CH_QUOTE;
  endfunction

  function automatic string keyword_rest(input kw_t kw);
    case (kw)
      KW_SCHEMES: return "chemes";
      KW_FACTS:   return "acts";
      KW_RULES:   return "ules";
      KW_QUERIES: return "ueries";
      default:    return "";
    endcase
  endfunction

  function automatic string full_keyword(input int i);
    case (i)
      0:       return "Schemes";
      1:       return "Facts";
      2:       return "Rules";
      default: return "Queries";
    endcase
  endfunction

  function automatic void lex_reset();
    lex_mode  = MODE_IDLE;
    lex_line  = 16'd1;
    lex_col   = '0;
    lex_start = '0;
    lex_len   = '0;
    lex_kw    = KW_NONE;
    lex_kw_ok = 1'b0;
  endfunction

  function automatic void push_token(input kind_t kind, input logic [15:0] col,
                                     input logic [15:0] len);
    token_t t;
    t.kind = kind;
    t.line = lex_line;
    t.col  = col;
    t.len  = len;
    t.last = 1'b0;
    expected_tokens.insert(expected_tokens.size(), t);
    step_results++;
  endfunction

  function automatic void close_ident();
    kind_t kind;
    string rest;
    kind = KIND_ID;
    rest = keyword_rest(lex_kw);
    if (lex_kw != KW_NONE && lex_kw_ok && lex_len == rest.len() + 1) begin
      case (lex_kw)
        KW_SCHEMES: kind = KIND_SCHEMES;
        KW_FACTS:   kind = KIND_FACTS;
        KW_RULES:   kind = KIND_RULES;
        default:    kind = KIND_QUERIES;
      endcase
    end
    push_token(kind, lex_start, lex_len);
    lex_mode = MODE_IDLE;
  endfunction

  function automatic void halt_on_error(input logic [15:0] col);
    push_token(KIND_ERROR, col, 16'd0);
    lex_mode = MODE_HALT;
  endfunction

  function automatic void lex_start_char(input logic [7:0] b);
    case (b)
      CH_COMMA:  push_token(KIND_COMMA, lex_col, 16'd1);
      CH_PERIOD: push_token(KIND_PERIOD, lex_col, 16'd1);
      CH_QMARK:  push_token(KIND_QMARK, lex_col, 16'd1);
      CH_LPAREN: push_token(KIND_LPAREN, lex_col, 16'd1);
      CH_RPAREN: push_token(KIND_RPAREN, lex_col, 16'd1);
      CH_HASH:   lex_mode = MODE_COMMENT;
      CH_COLON: begin
        lex_mode  = MODE_COLON;
        lex_start = lex_col;
      end
      CH_QUOTE: begin
        lex_mode  = MODE_STRING;
        lex_start = lex_col;
        lex_len   = '0;
      end
      default: begin
        if (is_letter(b)) begin
          lex_mode  = MODE_IDENT;
          lex_start = lex_col;
          lex_len   = 16'd1;
          case (b)
            "S":     lex_kw = KW_SCHEMES;
            "F":     lex_kw = KW_FACTS;
            "R":     lex_kw = KW_RULES;
            "Q":     lex_kw = KW_QUERIES;
            default: lex_kw = KW_NONE;
          endcase
          lex_kw_ok = (lex_kw != KW_NONE);
        end else if (!is_blank(b)) begin
          halt_on_error(lex_col);
        end
      end
    endcase
  endfunction

  // expected tokens for one accepted word
  function automatic void lex_step(input logic [7:0] b, input logic eoi);
    bit    rescan;
    string rest;
    int    p;
    rescan = 1'b0;
    step_results = 0;
    if (lex_mode == MODE_HALT) return;
    if (eoi) begin
      if (lex_mode == MODE_IDENT) close_ident();
      else if (lex_mode == MODE_COLON) push_token(KIND_COLON, lex_start, 16'd1);
      else if (lex_mode == MODE_STRING) halt_on_error(lex_start);
      if (lex_mode != MODE_HALT) lex_reset();
    end else begin
      case (lex_mode)
        MODE_COMMENT: begin
          if (b == CH_NL) lex_mode = MODE_IDLE;
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            push_token(KIND_STRING, lex_start, lex_len);
            lex_mode = MODE_IDLE;
          end else if (b == CH_NL || b == CH_NUL) begin
            halt_on_error(lex_start);
          end else begin
            lex_len = sat_bump(lex_len);
          end
        end
        MODE_IDENT: begin
          if (is_letter(b) || is_digit(b)) begin
            if (lex_kw_ok && lex_kw != KW_NONE) begin
              rest = keyword_rest(lex_kw);
              p = lex_len - 1;
              if (p >= rest.len() || rest[p] != b) lex_kw_ok = 1'b0;
            end
            lex_len = sat_bump(lex_len);
          end else begin
            close_ident();
            rescan = 1'b1;
          end
        end
        MODE_COLON: begin
          if (b == CH_DASH) begin
            push_token(KIND_COLONDASH, lex_start, 16'd2);
          end else begin
            push_token(KIND_COLON, lex_start, 16'd1);
            rescan = 1'b1;
          end
          lex_mode = MODE_IDLE;
        end
        default: rescan = 1'b1;
      endcase
      if (rescan && b != CH_NL) lex_start_char(b);
      if (b == CH_NL && lex_mode != MODE_HALT) begin
        lex_line = sat_bump(lex_line);
        lex_col  = '0;
      end else begin
        lex_col = sat_bump(lex_col);
      end
    end
    if (step_results > 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= 50)
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic send_word(input logic [7:0] b, input logic eoi);
    int gap;
    bit rdy;
    gap = send_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eoi;
    // ready is sampled mid-cycle, where nothing is switching
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
    lex_step(b, eoi);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    return (r < 52) ? rand_letter() : 8'("0" + r - 52);
  endfunction

  // string body byte: anything but newline, quote and nul
  function automatic logic [7:0] rand_body_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_NL || c == CH_QUOTE);
    return c;
  endfunction

  task automatic send_random_piece();
    string      w;
    int         i;
    int         n;
    int         pos;
    logic [7:0] c;
    case ($urandom_range(0, 10))
      0, 1: send_text(full_keyword($urandom_range(0, 3)));
      2: begin
        // near miss: cut short, run long, or one letter in the wrong case
        w = full_keyword($urandom_range(0, 3));
        n = $urandom_range(0, 2);
        pos = $urandom_range(0, w.len() - 1);
        for (i = 0; i < w.len(); i++) begin
          c = w[i];
          if (n == 2 && i == pos) c = c ^ 8'h20;
          if (!(n == 0 && i > pos)) send_word(c, 1'b0);
        end
        if (n == 1) send_word(rand_alnum(), 1'b0);
      end
      3: begin
        case ($urandom_range(0, 5))
          0:       send_word("S", 1'b0);
          1:       send_word("Q", 1'b0);
          default: send_word(rand_letter(), 1'b0);
        endcase
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) send_word(rand_alnum(), 1'b0);
      end
      4, 5: begin
        case ($urandom_range(0, 6))
          0: send_word(CH_COMMA, 1'b0);
          1: send_word(CH_PERIOD, 1'b0);
          2: send_word(CH_QMARK, 1'b0);
          3: send_word(CH_LPAREN, 1'b0);
          4: send_word(CH_RPAREN, 1'b0);
          5: send_word(CH_COLON, 1'b0);
          default: begin
            send_word(CH_COLON, 1'b0);
            send_word(CH_DASH, 1'b0);
          end
        endcase
      end
      6: begin
        send_word(CH_QUOTE, 1'b0);
        n = $urandom_range(0, 12);
        for (i = 0; i < n; i++) send_word(rand_body_byte(), 1'b0);
        send_word(CH_QUOTE, 1'b0);
      end
      7: begin
        send_word(CH_HASH, 1'b0);
        n = $urandom_range(0, 10);
        for (i = 0; i < n; i++) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
          send_word(c, 1'b0);
        end
        send_word(CH_NL, 1'b0);
      end
      8: begin
        case ($urandom_range(0, 3))
          0:       send_word(CH_NUL, 1'b0);
          1:       send_word(CH_SPACE, 1'b0);
          default: send_word(8'($urandom_range(CH_TAB, CH_CR)), 1'b0);
        endcase
      end
      9: send_word(CH_NL, 1'b0);
      default: begin
        if ($urandom_range(0, 3) == 0) send_end();
        else send_word(CH_NL, 1'b0);
      end
    endcase
    case ($urandom_range(0, 3))
      2:       send_word(CH_SPACE, 1'b0);
      3:       send_word(CH_NL, 1'b0);
      default: ;
    endcase
  endtask

  task automatic test_directed_tokens();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    send_text("Rules:-(a1,'x");
    send_word(8'hC8, 1'b0);
    send_text("'):,?.");
    send_word(CH_NUL, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(CH_CR, 1'b0);
    send_text("#c");
    send_word(8'hFF, 1'b0);
    send_word(CH_NL, 1'b0);
    send_text("Facts:");
    send_end();
    send_text("Q");
    send_end();
  endtask

  task automatic test_random_documents();
    int first;
    int pieces;
    first = words_sent;
    pieces = 0;
    while (words_sent - first < 800) begin
      if (pieces % 40 == 0) begin
        send_idle_on = ($urandom_range(0, 4) != 0);
        recv_idle_on = ($urandom_range(0, 4) != 0);
      end
      send_random_piece();
      pieces++;
    end
    send_end();
  endtask

  // the scanner halts for good here, so this runs last
  task automatic test_error_halt();
    logic [7:0] b;
    bit         prefixed;
    int         i;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    prefixed = 1'($urandom_range(0, 1));
    if (prefixed) send_text("Rules");
    case ($urandom_range(0, 3))
      0: begin
        do b = 8'($urandom_range(0, 255));
        while (starts_token(b) || (prefixed && is_digit(b)));
        send_word(b, 1'b0);
      end
      1: begin
        send_text("'ab");
        send_word(CH_NL, 1'b0);
      end
      2: begin
        send_text("'ab");
        send_word(CH_NUL, 1'b0);
      end
      default: begin
        send_text("'ab");
        send_end();
      end
    endcase
    for (i = 0; i < 12; i++)
      send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= 0;
    end else if (ready_hold != 0) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= ready_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (recv_idle_on) ready_hold <= pick_gap();
    end
  end

  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected result word, kind", 32'(m_axis_tuser), 0);
      end else begin
        want_tok = expected_tokens.pop_front();
        if (m_axis_tuser != want_tok.kind)
          report_mismatch("token_kind", 32'(m_axis_tuser), 32'(want_tok.kind));
        if (m_axis_tdata[15:0] != want_tok.line)
          report_mismatch("line_number", 32'(m_axis_tdata[15:0]), 32'(want_tok.line));
        if (m_axis_tdata[31:16] != want_tok.col)
          report_mismatch("start_column", 32'(m_axis_tdata[31:16]), 32'(want_tok.col));
        if (m_axis_tdata[47:32] != want_tok.len)
          report_mismatch("token_length", 32'(m_axis_tdata[47:32]), 32'(want_tok.len));
        if (m_axis_tlast != want_tok.last)
          report_mismatch("last_of_run", 32'(m_axis_tlast), 32'(want_tok.last));
      end
    end
  end

  initial begin
    int i;
    lex_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_tokens();
    test_random_documents();
    test_error_halt();
    s_axis_tvalid <= 1'b0;
    for (i = 0; i < 5000 && expected_tokens.size() != 0; i++) @(posedge clk);
    if (expected_tokens.size() != 0)
      report_mismatch("results never delivered, count", 0, expected_tokens.size());
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
hdl/dts_pkg.sv
hdl/dts_core.sv
hdl/dts_out_fifo.sv
hdl/datalog_token_scanner.sv
sim/datalog_token_scanner_tb.sv
